// ----- rtl/core/loader_charger_sequencer_top_macros.svh -----
// Assertion macros for the loader and charger sequencer.
// Taken in by the top level; needs no other file.
`ifndef LOADER_CHARGER_SEQUENCER_TOP_MACROS_SVH
`define LOADER_CHARGER_SEQUENCER_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LCS_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define LCS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/core/lcs_pkg.sv -----
// Shared types and constants for the loader and charger sequencer.
// Used by every module of the block; depends on nothing.
`default_nettype none

package lcs_pkg;

	localparam int COUNT_WIDTH_DEF = 8;
	localparam int PADDR_W = 4;
	localparam int PDATA_W = 32;

	// Configuration register indexes (byte address bits [3:2]).
	localparam logic [1:0] REG_LOADING_TICKS = 2'd0;
	localparam logic [1:0] REG_SERVO_CENTER  = 2'd1;
	localparam logic [1:0] REG_OPEN_OFFSET   = 2'd2;
	localparam logic [1:0] REG_CLOSE_OFFSET  = 2'd3;

	localparam logic [7:0]  LOADING_TICKS_RST = 8'd20;
	localparam logic [14:0] SERVO_CENTER_RST  = 15'd12000;
	localparam logic [12:0] OPEN_OFFSET_RST   = 13'd2200;
	localparam logic [12:0] CLOSE_OFFSET_RST  = 13'd2800;

	// Request codes.
	localparam logic [1:0] REQ_FRAME   = 2'd0;
	localparam logic [1:0] REQ_TIMEOUT = 2'd1;
	localparam logic [1:0] REQ_TICK    = 2'd2;

	localparam logic [14:0] PULSE_RST    = 15'd12000;
	localparam logic [14:0] STICK_OFFSET = 15'd3936;
	localparam logic [13:0] REAR_OFFSET  = 14'd7904;

	// Battery scaling: millivolts = (sample * 10185) >> 12, then /10 by reciprocal.
	localparam logic [13:0] BATT_SCALE  = 14'd10185;
	localparam int          BATT_SHIFT  = 12;
	localparam logic [15:0] DIV10_RECIP = 16'd52429;
	localparam int          DIV10_SHIFT = 19;

	typedef enum logic [6:0] {
		MODE_IDLE      = 7'b0000001,
		MODE_LOAD_OUT  = 7'b0000010,
		MODE_LOAD_BACK = 7'b0000100,
		MODE_RECHECK   = 7'b0001000,
		MODE_EMPTY     = 7'b0010000,
		MODE_CHARGING  = 7'b0100000,
		MODE_FIRED     = 7'b1000000
	} mode_t;

	typedef struct packed {
		logic [7:0]  loading_ticks;
		logic [14:0] servo_center;
		logic [12:0] open_offset;
		logic [12:0] close_offset;
	} cfg_t;

	typedef struct packed {
		logic [1:0]  req_type;
		logic        charge_switch_off;
		logic        trigger;
		logic [7:0]  throttle_byte;
		logic [7:0]  roll_byte;
		logic [7:0]  turn_byte;
		logic        charged_sensor;
		logic        broken_sensor;
		logic        empty_sensor;
		logic [11:0] battery_sample;
	} req_item_t;

	// Everything the sequencer produces for one item.
	typedef struct packed {
		logic [14:0] loader_servo_a;
		logic [14:0] loader_servo_b;
		logic [14:0] throttle_pulse;
		logic [14:0] roll_pulse;
		logic [14:0] front_steer_pulse;
		logic [13:0] rear_steer_pulse;
		logic        charge_enable;
		logic        fire;
		logic [2:0]  status_flags;
	} seq_res_t;

	typedef struct packed {
		logic [14:0] loader_servo_a;
		logic [14:0] loader_servo_b;
		logic [14:0] throttle_pulse;
		logic [14:0] roll_pulse;
		logic [14:0] front_steer_pulse;
		logic [13:0] rear_steer_pulse;
		logic        charge_enable;
		logic        fire;
		logic [2:0]  status_flags;
		logic [9:0]  battery_centivolts;
	} rsp_item_t;

endpackage

`default_nettype wire

// ----- rtl/core/lcs_apb.sv -----
// Configuration registers of the loader and charger sequencer behind an APB-style port.
// Depends on lcs_pkg.
`default_nettype none

module lcs_apb (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [lcs_pkg::PADDR_W-1:0]   paddr,
	input  wire logic [lcs_pkg::PDATA_W-1:0]   pwdata,
	output logic      [lcs_pkg::PDATA_W-1:0]   prdata,
	output logic                               pready,
	output lcs_pkg::cfg_t                      cfg
);

	lcs_pkg::cfg_t cfg_q;
	logic [1:0]    reg_idx;
	logic          wr_en;

	assign pready  = 1'b1;
	assign reg_idx = paddr[3:2];
	assign wr_en   = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.loading_ticks <= lcs_pkg::LOADING_TICKS_RST;
			cfg_q.servo_center  <= lcs_pkg::SERVO_CENTER_RST;
			cfg_q.open_offset   <= lcs_pkg::OPEN_OFFSET_RST;
			cfg_q.close_offset  <= lcs_pkg::CLOSE_OFFSET_RST;
		end else if (wr_en) begin
			unique case (reg_idx)
				lcs_pkg::REG_LOADING_TICKS: cfg_q.loading_ticks <= pwdata[7:0];
				lcs_pkg::REG_SERVO_CENTER:  cfg_q.servo_center  <= pwdata[14:0];
				lcs_pkg::REG_OPEN_OFFSET:   cfg_q.open_offset   <= pwdata[12:0];
				lcs_pkg::REG_CLOSE_OFFSET:  cfg_q.close_offset  <= pwdata[12:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			lcs_pkg::REG_LOADING_TICKS: prdata = {24'd0, cfg_q.loading_ticks};
			lcs_pkg::REG_SERVO_CENTER:  prdata = {17'd0, cfg_q.servo_center};
			lcs_pkg::REG_OPEN_OFFSET:   prdata = {19'd0, cfg_q.open_offset};
			lcs_pkg::REG_CLOSE_OFFSET:  prdata = {19'd0, cfg_q.close_offset};
			default:                    prdata = '0;
		endcase
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

// ----- rtl/core/lcs_seq.sv -----
// Loader and charger mode sequencer with held pulse widths and status flags.
// Computes the next state for the item in the input register. Depends on lcs_pkg.
`default_nettype none

module lcs_seq #(
	parameter int COUNT_WIDTH = lcs_pkg::COUNT_WIDTH_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire lcs_pkg::cfg_t     cfg,
	input  wire lcs_pkg::req_item_t item,
	input  wire logic              step,
	output lcs_pkg::seq_res_t      res
);

	lcs_pkg::mode_t         mode_q, mode_d;
	logic [COUNT_WIDTH-1:0] cnt_q, cnt_d, cnt_load;
	logic                   prev_on_q, prev_on_d;
	logic                   empty_q, empty_d;
	logic                   charged_q, charged_d;
	logic                   broken_q, broken_d;
	logic [14:0]            servo_a_q, servo_a_d, servo_b_q, servo_b_d;
	logic [14:0]            thr_q, thr_d, roll_q, roll_d, front_q, front_d;
	logic [13:0]            rear_q, rear_d;
	logic [14:0]            open_a, open_b, close_a, close_b;
	logic                   loaded, fire, enable;

	function automatic logic [14:0] sat15(input logic signed [16:0] v);
		logic [14:0] r;
		if (v < 0)
			r = '0;
		else if (v > 17'sd32767)
			r = 15'h7FFF;
		else
			r = v[14:0];
		return r;
	endfunction

	assign open_a  = sat15($signed({2'b00, cfg.servo_center}) - $signed({4'b0000, cfg.open_offset}));
	assign open_b  = sat15($signed({2'b00, cfg.servo_center}) + $signed({4'b0000, cfg.open_offset}));
	assign close_a = sat15($signed({2'b00, cfg.servo_center}) + $signed({4'b0000, cfg.close_offset}));
	assign close_b = sat15($signed({2'b00, cfg.servo_center}) - $signed({4'b0000, cfg.close_offset}));

	assign cnt_load = COUNT_WIDTH'(cfg.loading_ticks);
	assign loaded   = !item.empty_sensor;

	always_comb begin
		mode_d    = mode_q;
		cnt_d     = cnt_q;
		prev_on_d = prev_on_q;
		empty_d   = empty_q;
		charged_d = charged_q;
		broken_d  = broken_q;
		servo_a_d = servo_a_q;
		servo_b_d = servo_b_q;
		thr_d     = thr_q;
		roll_d    = roll_q;
		front_d   = front_q;
		rear_d    = rear_q;
		enable    = 1'b0;
		fire      = 1'b0;
		unique case (item.req_type)
			lcs_pkg::REQ_TICK: begin
				if (cnt_q != '0)
					cnt_d = cnt_q - 1'b1;
			end
			lcs_pkg::REQ_FRAME: begin
				// Stick mapping: byte*63 + offset is built as byte*64 - byte.
				thr_d     = 15'({item.throttle_byte, 6'd0}) - 15'(item.throttle_byte)
					+ lcs_pkg::STICK_OFFSET;
				roll_d    = 15'({item.roll_byte, 6'd0}) - 15'(item.roll_byte)
					+ lcs_pkg::STICK_OFFSET;
				front_d   = 15'({item.turn_byte, 6'd0}) - 15'(item.turn_byte)
					+ lcs_pkg::STICK_OFFSET;
				rear_d    = 14'({item.turn_byte, 5'd0}) + lcs_pkg::REAR_OFFSET;
				charged_d = item.charged_sensor;
				broken_d  = item.broken_sensor;
				if (!item.charge_switch_off) begin
					prev_on_d = 1'b1;
					if (!prev_on_q) begin
						// Rising edge of the charge switch starts a load or goes to charging.
						if (loaded) begin
							mode_d = lcs_pkg::MODE_CHARGING;
						end else begin
							cnt_d  = cnt_load;
							mode_d = lcs_pkg::MODE_LOAD_OUT;
						end
					end else if (item.broken_sensor) begin
						servo_a_d = close_a;
						servo_b_d = close_b;
					end else begin
						unique case (mode_q)
							lcs_pkg::MODE_LOAD_OUT: begin
								servo_a_d = open_a;
								servo_b_d = open_b;
								if (cnt_q == '0) begin
									cnt_d  = cnt_load;
									mode_d = lcs_pkg::MODE_LOAD_BACK;
								end
							end
							lcs_pkg::MODE_LOAD_BACK: begin
								servo_a_d = close_a;
								servo_b_d = close_b;
								if (cnt_q == '0)
									mode_d = lcs_pkg::MODE_RECHECK;
							end
							lcs_pkg::MODE_RECHECK: begin
								mode_d = loaded ? lcs_pkg::MODE_CHARGING : lcs_pkg::MODE_EMPTY;
							end
							lcs_pkg::MODE_EMPTY: begin
								empty_d = 1'b1;
							end
							lcs_pkg::MODE_CHARGING: begin
								enable = 1'b1;
								if (item.charged_sensor && item.trigger) begin
									fire   = 1'b1;
									mode_d = lcs_pkg::MODE_FIRED;
								end
							end
							default: begin
								// Idle and after firing both allow a shot when charged.
								fire = item.charged_sensor && item.trigger;
							end
						endcase
					end
				end else begin
					prev_on_d = 1'b0;
					if (mode_q == lcs_pkg::MODE_LOAD_OUT) begin
						servo_a_d = open_a;
						servo_b_d = open_b;
						if (cnt_q == '0) begin
							cnt_d  = cnt_load;
							mode_d = lcs_pkg::MODE_LOAD_BACK;
						end
					end else if (mode_q == lcs_pkg::MODE_LOAD_BACK) begin
						servo_a_d = close_a;
						servo_b_d = close_b;
						if (cnt_q == '0)
							mode_d = lcs_pkg::MODE_IDLE;
					end else begin
						empty_d   = 1'b0;
						mode_d    = lcs_pkg::MODE_IDLE;
						servo_a_d = close_a;
						servo_b_d = close_b;
					end
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= lcs_pkg::MODE_IDLE;
			cnt_q     <= '0;
			prev_on_q <= 1'b0;
			empty_q   <= 1'b0;
			charged_q <= 1'b0;
			broken_q  <= 1'b0;
			servo_a_q <= lcs_pkg::PULSE_RST;
			servo_b_q <= lcs_pkg::PULSE_RST;
			thr_q     <= lcs_pkg::PULSE_RST;
			roll_q    <= lcs_pkg::PULSE_RST;
			front_q   <= lcs_pkg::PULSE_RST;
			rear_q    <= lcs_pkg::PULSE_RST[13:0];
		end else if (step) begin
			mode_q    <= mode_d;
			cnt_q     <= cnt_d;
			prev_on_q <= prev_on_d;
			empty_q   <= empty_d;
			charged_q <= charged_d;
			broken_q  <= broken_d;
			servo_a_q <= servo_a_d;
			servo_b_q <= servo_b_d;
			thr_q     <= thr_d;
			roll_q    <= roll_d;
			front_q   <= front_d;
			rear_q    <= rear_d;
		end
	end

	assign res.loader_servo_a    = servo_a_d;
	assign res.loader_servo_b    = servo_b_d;
	assign res.throttle_pulse    = thr_d;
	assign res.roll_pulse        = roll_d;
	assign res.front_steer_pulse = front_d;
	assign res.rear_steer_pulse  = rear_d;
	assign res.charge_enable     = enable;
	assign res.fire              = fire;
	assign res.status_flags      = {charged_d, broken_d, empty_d};

endmodule

`default_nettype wire

// ----- rtl/core/loader_charger_sequencer_top.sv -----
// Top level of the loader and charger sequencer: input register, battery scaling,
// result register and assertions. Depends on lcs_pkg, lcs_apb, lcs_seq and the macro header.
//
//   Channel   Signals                                   Direction
//   req       req_valid, req_ready, req_data            request items in
//   rsp       rsp_valid, rsp_ready, rsp_data            result items out
//   apb       psel, penable, pwrite, paddr, pwdata,     register writes and reads
//             prdata, pready
//
// An item sits first in the input register and then in the result register, where result
// valid is registered; one item is taken every cycle while the result is not stalled.
// The battery multiply sits before the input register and the divide by ten after it.
// Reset clears both valid flags and puts the sequencer in idle with all pulses centered.
// A stalled result holds the result register and the input register fills behind it.
`default_nettype none

`include "loader_charger_sequencer_top_macros.svh"

module loader_charger_sequencer_top #(
	parameter int COUNT_WIDTH = lcs_pkg::COUNT_WIDTH_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          req_valid,
	output logic                               req_ready,
	input  wire lcs_pkg::req_item_t            req_data,
	output logic                               rsp_valid,
	input  wire logic                          rsp_ready,
	output lcs_pkg::rsp_item_t                 rsp_data,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [lcs_pkg::PADDR_W-1:0]   paddr,
	input  wire logic [lcs_pkg::PDATA_W-1:0]   pwdata,
	output logic      [lcs_pkg::PDATA_W-1:0]   prdata,
	output logic                               pready
);

	lcs_pkg::cfg_t      cfg;
	lcs_pkg::req_item_t item_s1;
	lcs_pkg::seq_res_t  seq_res;
	lcs_pkg::rsp_item_t data_s2;
	logic               valid_s1, valid_s2, adv;
	logic [25:0]        batt_prod;
	logic [13:0]        mv_s1;
	logic [14:0]        mv_round;
	logic [30:0]        div_prod;
	logic [9:0]         centivolts;

	lcs_apb u_apb (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	lcs_seq #(
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.item   (item_s1),
		.step   (adv),
		.res    (seq_res)
	);

	assign adv       = valid_s1 && (!valid_s2 || rsp_ready);
	assign req_ready = !valid_s1 || adv;

	// Millivolts from the converter sample; the product needs 26 bits.
	assign batt_prod = 26'(req_data.battery_sample) * 26'(lcs_pkg::BATT_SCALE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (req_ready)
			valid_s1 <= req_valid;
	end

	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			item_s1 <= req_data;
			mv_s1   <= batt_prod[lcs_pkg::BATT_SHIFT +: 14];
		end
	end

	// Rounding half up is floor((mv + 5) / 10); the reciprocal is exact below 2^15.
	assign mv_round   = 15'(mv_s1) + 15'd5;
	assign div_prod   = 31'(mv_round) * 31'(lcs_pkg::DIV10_RECIP);
	assign centivolts = div_prod[lcs_pkg::DIV10_SHIFT +: 10];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s2 <= 1'b0;
		else if (!valid_s2 || rsp_ready)
			valid_s2 <= valid_s1;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			data_s2.loader_servo_a     <= seq_res.loader_servo_a;
			data_s2.loader_servo_b     <= seq_res.loader_servo_b;
			data_s2.throttle_pulse     <= seq_res.throttle_pulse;
			data_s2.roll_pulse         <= seq_res.roll_pulse;
			data_s2.front_steer_pulse  <= seq_res.front_steer_pulse;
			data_s2.rear_steer_pulse   <= seq_res.rear_steer_pulse;
			data_s2.charge_enable      <= seq_res.charge_enable;
			data_s2.fire               <= seq_res.fire;
			data_s2.status_flags       <= seq_res.status_flags;
			data_s2.battery_centivolts <= centivolts;
		end
	end

	assign rsp_valid = valid_s2;
	assign rsp_data  = data_s2;

	// A fire command only leaves on a frame that reported the capacitor charged.
	`LCS_ASSERT_SAME(a_fire_needs_charged, clk, arst_n, rsp_valid && rsp_data.fire, rsp_data.status_flags[2], "fire without charged flag")
	// The charger is never enabled on a frame that reported a fault.
	`LCS_ASSERT_SAME(a_enable_not_broken, clk, arst_n, rsp_valid && rsp_data.charge_enable, !rsp_data.status_flags[1], "charge enable with broken flag")
	// An item waiting behind a stalled result stays in the input register untouched.
	`LCS_ASSERT_NEXT(a_s1_holds, clk, arst_n, valid_s1 && valid_s2 && !rsp_ready, valid_s1 && $stable(item_s1) && $stable(mv_s1), "input register lost its item")

endmodule

`default_nettype wire
